// ----- rtl/core/irtd_pkg.sv -----
`default_nettype none
package irtd_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam logic [32:0] COVER_MAX = '1;
	localparam logic [7:0] FILL_HDR = 8'h80;
	localparam logic [7:0] FILL_BIAS = 8'h7f;

	typedef enum logic [2:0] {
		CMD_START_IMAGE = 3'd0,
		CMD_START_TILE  = 3'd1,
		CMD_DATA_BYTE   = 3'd2,
		CMD_CONTINUE    = 3'd3,
		CMD_END_IMAGE   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_RECT = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_COVERAGE = 2'd3
	} status_t;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] tile_x_first;
		logic [15:0] tile_y_first;
		logic [15:0] tile_x_last;
		logic [15:0] tile_y_last;
		logic        raw_mode;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic        pixel_valid;
		logic [15:0] pixel_column;
		logic [15:0] buffer_row;
		logic [1:0]  byte_lane;
		logic [7:0]  byte_value;
		logic        run_pending;
		logic [1:0]  status;
	} result_t;

	// Classified operation handed from the front to the back.
	typedef struct packed {
		cmd_t        cmd;
		logic        bad_rect;
		logic [15:0] left;
		logic [15:0] top;
		logic [16:0] cols;
		logic [16:0] rows;
		logic        raw;
		logic [7:0]  data;
		logic [33:0] area;
	} op_t;

	// Plane k (or byte k of a raw pixel) goes to lane 3,0,1,2.
	function automatic logic [1:0] lane_of(input logic [1:0] plane);
		logic [1:0] lane;
		case (plane)
			2'd0: lane = 2'd3;
			2'd1: lane = 2'd0;
			2'd2: lane = 2'd1;
			default: lane = 2'd2;
		endcase
		return lane;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/iff_rle_planar_tile_decoder_unit.sv -----
// Channel   Direction  Handshake                      Payload
// item      in         item_valid / item_ready        item_t
// result    out        result_valid / result_ready    result_t
// config    in         APB (psel, penable, pwrite)    image_width, image_height
//
// The unit takes one transaction per clock cycle while the queue has room; the
// sustained rate is set by the back-end tile walker, which a held result stalls.
// A result passes from the front register through the queue to the result
// register; a full queue or a held result can keep it waiting between them.
// Reset is asynchronous; it clears tile state, coverage, sizes and valid bits.
// A stalled result stalls the back end; the front runs on until the queue is full.
`default_nettype none
module iff_rle_planar_tile_decoder_unit import irtd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// Image size registers: user writes only while the unit is idle; not enforced.
	logic [16:0] image_width_q, image_height_q;
	logic        push, fifo_full, fifo_ne, pop;
	op_t         push_op, pop_op;
	reg_idx_t    reg_idx;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= '0;
			image_height_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_IMAGE_WIDTH: image_width_q <= pwdata[16:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH: prdata = {15'd0, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {15'd0, image_height_q};
			default: prdata = '0;
		endcase
	end

	// The front masks coordinates, checks the rectangle and forms its area.
	irtd_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.image_width(image_width_q), .image_height(image_height_q),
		.push(push), .push_op(push_op), .fifo_full(fifo_full)
	);

	// The queue decouples classification from the stateful walker.
	irtd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_op(push_op), .full(fifo_full),
		.not_empty(fifo_ne), .pop(pop), .pop_op(pop_op)
	);

	// The back end owns tile, run and coverage state and the result register.
	irtd_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(fifo_ne), .op(pop_op), .pop(pop),
		.image_width(image_width_q), .image_height(image_height_q),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

endmodule
`default_nettype wire

// ----- rtl/core/irtd_front.sv -----
`default_nettype none
module irtd_front import irtd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	input  wire logic [16:0] image_width,
	input  wire logic [16:0] image_height,
	output logic             push,
	output op_t              push_op,
	input  wire logic        fifo_full
);

	localparam logic [15:0] CoordMask = 16'((17'd1 << COORD_BITS) - 17'd1);

	logic        v_s1;
	op_t         op_s1;
	logic [15:0] x1, y1, x2, y2;
	logic        known;
	op_t         op_in;

	always_comb begin
		x1 = item.tile_x_first & CoordMask;
		y1 = item.tile_y_first & CoordMask;
		x2 = item.tile_x_last & CoordMask;
		y2 = item.tile_y_last & CoordMask;
		known = (item.command <= CMD_END_IMAGE);
		op_in.cmd = cmd_t'(item.command);
		op_in.bad_rect = (x1 > x2) || (y1 > y2) || ({1'b0, x2} >= image_width)
			|| ({1'b0, y2} >= image_height);
		op_in.left = x1;
		op_in.top = y1;
		op_in.cols = {1'b0, x2} - {1'b0, x1} + 17'd1;
		op_in.rows = {1'b0, y2} - {1'b0, y1} + 17'd1;
		op_in.raw = item.raw_mode;
		op_in.data = item.data_byte;
		op_in.area = '0;
	end

	assign item_ready = !v_s1 || !fifo_full;
	assign push = v_s1 && !fifo_full;

	always_comb begin
		push_op = op_s1;
		push_op.area = op_s1.cols * op_s1.rows;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_ready) begin
			v_s1 <= item_valid && known;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1 <= op_in;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/irtd_fifo.sv -----
`default_nettype none
module irtd_fifo import irtd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	output logic      not_empty,
	input  wire logic pop,
	output op_t       pop_op
);

	op_t        mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_op = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_op;
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue read while empty");

endmodule
`default_nettype wire

// ----- rtl/core/irtd_back.sv -----
`default_nettype none
module irtd_back import irtd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        op_valid,
	input  wire op_t         op,
	output logic             pop,
	input  wire logic [16:0] image_width,
	input  wire logic [16:0] image_height,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result
);

	localparam logic [15:0] CoordMask = 16'((17'd1 << COORD_BITS) - 17'd1);

	logic [15:0] tile_left_q, tile_top_q;
	logic [16:0] tile_cols_q, tile_rows_q, cur_column_q, cur_row_q;
	logic        raw_tile_q, await_q;
	logic [1:0]  cur_plane_q;
	logic [7:0]  fill_left_q, literal_left_q, fill_byte_q;
	logic [32:0] covered_q;
	logic [33:0] area_q;

	logic [15:0] n_left, n_top;
	logic [16:0] n_cols, n_rows, n_col, n_row;
	logic        n_raw, n_await;
	logic [1:0]  n_plane;
	logic [7:0]  n_fill, n_lit, n_fbyte;
	logic [32:0] n_cov;
	logic [34:0] cov_sum;
	logic        has_res, do_emit, clear, ovf;
	logic [7:0]  emit_val;
	logic [16:0] e_col, e_row;
	logic [1:0]  e_plane;
	result_t     res;

	always_comb begin
		n_left = tile_left_q; n_top = tile_top_q;
		n_cols = tile_cols_q; n_rows = tile_rows_q;
		n_col = cur_column_q; n_row = cur_row_q;
		n_raw = raw_tile_q; n_await = await_q; n_plane = cur_plane_q;
		n_fill = fill_left_q; n_lit = literal_left_q; n_fbyte = fill_byte_q;
		n_cov = covered_q;
		cov_sum = {2'b0, covered_q} + {1'b0, op.area};
		has_res = 1'b1;
		do_emit = 1'b0;
		clear = 1'b0;
		ovf = 1'b0;
		emit_val = op.data;
		e_col = cur_column_q; e_row = cur_row_q; e_plane = cur_plane_q;
		res = '0;
		res.status = ST_OK;
		case (op.cmd)
			CMD_START_IMAGE: begin
				has_res = 1'b0;
				n_cov = '0;
				clear = 1'b1;
			end
			CMD_START_TILE: begin
				clear = 1'b1;
				if (op.bad_rect) begin
					res.status = ST_BAD_RECT;
				end else begin
					n_cov = (cov_sum > {2'b0, COVER_MAX}) ? COVER_MAX : cov_sum[32:0];
				end
			end
			CMD_DATA_BYTE: begin
				if (tile_cols_q != '0) begin
					if (raw_tile_q) begin
						do_emit = 1'b1;
					end else if (await_q) begin
						n_await = 1'b0;
						n_fbyte = op.data;
						if (fill_left_q != '0) n_fill = fill_left_q - 8'd1;
						do_emit = 1'b1;
					end else if (fill_left_q != '0) begin
						do_emit = 1'b0;
					end else if (literal_left_q != '0) begin
						n_lit = literal_left_q - 8'd1;
						do_emit = 1'b1;
					end else if ((op.data & FILL_HDR) != '0) begin
						n_fill = op.data - FILL_BIAS;
						n_await = 1'b1;
					end else begin
						n_lit = op.data + 8'd1;
					end
				end
			end
			CMD_CONTINUE: begin
				if (tile_cols_q != '0 && !raw_tile_q && !await_q && fill_left_q != '0) begin
					n_fill = fill_left_q - 8'd1;
					emit_val = fill_byte_q;
					do_emit = 1'b1;
				end
			end
			CMD_END_IMAGE: begin
				if ({1'b0, covered_q} != area_q) res.status = ST_COVERAGE;
			end
			default: has_res = 1'b0;
		endcase

		if (do_emit) begin
			if (cur_column_q >= tile_cols_q) begin
				e_col = '0;
				e_row = cur_row_q + 17'd1;
				if (e_row >= tile_rows_q) begin
					e_row = '0;
					if (raw_tile_q || cur_plane_q == 2'd3) ovf = 1'b1;
					else e_plane = cur_plane_q + 2'd1;
				end
			end
			if (ovf) begin
				clear = 1'b1;
				res.status = ST_OVERFLOW;
			end else begin
				res.pixel_valid = 1'b1;
				res.byte_lane = lane_of(e_plane);
				res.pixel_column = (tile_left_q + e_col[15:0]) & CoordMask;
				res.buffer_row = image_height[15:0] - 16'd1 - (tile_top_q + e_row[15:0]);
				res.byte_value = emit_val;
				n_row = e_row;
				if (raw_tile_q) begin
					n_plane = e_plane + 2'd1;
					n_col = (e_plane == 2'd3) ? e_col + 17'd1 : e_col;
				end else begin
					n_plane = e_plane;
					n_col = e_col + 17'd1;
				end
			end
		end

		if (clear) begin
			n_left = '0; n_top = '0; n_cols = '0; n_rows = '0; n_raw = 1'b0;
			n_col = '0; n_row = '0; n_plane = '0;
			n_fill = '0; n_lit = '0; n_await = 1'b0; n_fbyte = '0;
		end
		if (op.cmd == CMD_START_TILE && !op.bad_rect) begin
			n_left = op.left; n_top = op.top;
			n_cols = op.cols; n_rows = op.rows; n_raw = op.raw;
		end
		res.run_pending = (n_fill != '0) && !n_await && (n_cols != '0);
	end

	assign pop = op_valid && (!result_valid || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_left_q <= '0; tile_top_q <= '0;
			tile_cols_q <= '0; tile_rows_q <= '0;
			cur_column_q <= '0; cur_row_q <= '0;
			raw_tile_q <= 1'b0; await_q <= 1'b0; cur_plane_q <= '0;
			fill_left_q <= '0; literal_left_q <= '0; fill_byte_q <= '0;
			covered_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (pop) begin
				tile_left_q <= n_left; tile_top_q <= n_top;
				tile_cols_q <= n_cols; tile_rows_q <= n_rows;
				cur_column_q <= n_col; cur_row_q <= n_row;
				raw_tile_q <= n_raw; await_q <= n_await; cur_plane_q <= n_plane;
				fill_left_q <= n_fill; literal_left_q <= n_lit; fill_byte_q <= n_fbyte;
				covered_q <= n_cov;
			end
			if (pop) result_valid <= has_res;
			else if (result_ready) result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		area_q <= image_width * image_height;
		if (pop && has_res) result <= res;
	end

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pixel_valid |-> result.status == ST_OK)
		else $error("pixel write carries an error status");
	a_no_pend_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_OVERFLOW |-> !result.run_pending)
		else $error("overflow left a run pending");

endmodule
`default_nettype wire

// ----- dv/tb_iff_rle_planar_tile_decoder_unit.sv -----
`default_nettype none
module tb_iff_rle_planar_tile_decoder_unit;
	import irtd_pkg::*;

	// Generous bound: every transaction may wait out an 85 percent idle sender and an
	// 85 percent stalling receiver on top of the pipeline, plus the long hold-offs.
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	iff_rle_planar_tile_decoder_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow decoder state at the block's own widths, but for a wider plane counter.
	bit [16:0] img_w, img_h;
	bit [15:0] t_left, t_top;
	bit [16:0] t_cols, t_rows, at_col, at_row;
	bit        t_raw;
	bit [2:0]  at_plane;
	bit [7:0]  fill_cnt, lit_cnt, fill_val;
	bit        want_fill_val;
	bit [32:0] coverage;

	stim_t   stim_q[$];
	result_t expected_q[$];
	stim_t   in_flight;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      hold_order = 0;
	int      hold_served = 0;
	int      hold_left = 0;
	int      mismatches = 0;
	int      cycles = 0;

	function automatic void drop_tile();
		t_left = '0; t_top = '0; t_cols = '0; t_rows = '0; t_raw = 1'b0;
		at_col = '0; at_row = '0; at_plane = '0;
		fill_cnt = '0; lit_cnt = '0; want_fill_val = 1'b0; fill_val = '0;
	endfunction

	// The pending flag always reflects the state after the transaction is applied.
	function automatic result_t outcome(bit wr, bit [15:0] c, bit [15:0] r, bit [1:0] ln,
			bit [7:0] v, status_t st);
		result_t o;
		o.pixel_valid = wr;
		o.pixel_column = c;
		o.buffer_row = r;
		o.byte_lane = ln;
		o.byte_value = v;
		o.run_pending = (fill_cnt != 0) && !want_fill_val && (t_cols != 0);
		o.status = st;
		return o;
	endfunction

	// Writes one byte at the walker position; returns 0 when the tile overflows.
	function automatic bit write_byte(bit [7:0] v, output result_t o);
		bit [1:0]  lane;
		bit [15:0] c;
		bit [31:0] r;
		if (at_col >= t_cols) begin
			at_col = '0;
			at_row++;
			if (at_row >= t_rows) begin
				at_row = '0;
				if (t_raw || at_plane >= 3) begin
					drop_tile();
					o = outcome(0, 0, 0, 0, 0, ST_OVERFLOW);
					return 1'b0;
				end
				at_plane++;
			end
		end
		case (at_plane[1:0])
			2'd0: lane = 2'd3;
			2'd1: lane = 2'd0;
			2'd2: lane = 2'd1;
			default: lane = 2'd2;
		endcase
		c = t_left + at_col[15:0];
		r = 32'(img_h) - 32'd1 - (32'(t_top) + 32'(at_row));
		if (t_raw) begin
			at_plane++;
			if (at_plane >= 4) begin
				at_plane = '0;
				at_col++;
			end
		end else begin
			at_col++;
		end
		o = outcome(1, c, r[15:0], lane, v, ST_OK);
		return 1'b1;
	endfunction

	// Applies one accepted transaction; returns 1 when it produces a result.
	function automatic bit decode_item(item_t it, output result_t o);
		bit [7:0]  b;
		bit [31:0] span_w, span_h;
		bit [33:0] sum;
		b = it.data_byte;
		o = '0;
		case (it.command)
			CMD_START_IMAGE: begin
				coverage = '0;
				drop_tile();
				return 1'b0;
			end
			CMD_START_TILE: begin
				drop_tile();
				if (it.tile_x_first > it.tile_x_last || it.tile_y_first > it.tile_y_last ||
						17'(it.tile_x_last) >= img_w || 17'(it.tile_y_last) >= img_h) begin
					o = outcome(0, 0, 0, 0, 0, ST_BAD_RECT);
					return 1'b1;
				end
				span_w = 32'(it.tile_x_last) - 32'(it.tile_x_first) + 1;
				span_h = 32'(it.tile_y_last) - 32'(it.tile_y_first) + 1;
				sum = 34'(coverage) + 34'(64'(span_w) * 64'(span_h));
				coverage = sum[33] ? COVER_MAX : sum[32:0];
				t_left = it.tile_x_first;
				t_top = it.tile_y_first;
				t_cols = span_w[16:0];
				t_rows = span_h[16:0];
				t_raw = it.raw_mode;
				o = outcome(0, 0, 0, 0, 0, ST_OK);
				return 1'b1;
			end
			CMD_DATA_BYTE: begin
				if (t_cols == 0) begin
					o = outcome(0, 0, 0, 0, 0, ST_OK);
				end else if (t_raw) begin
					void'(write_byte(b, o));
				end else if (want_fill_val) begin
					want_fill_val = 1'b0;
					fill_val = b;
					if (fill_cnt > 0) fill_cnt--;
					if (write_byte(fill_val, o)) o.run_pending = fill_cnt != 0;
				end else if (fill_cnt > 0) begin
					o = outcome(0, 0, 0, 0, 0, ST_OK);
				end else if (lit_cnt > 0) begin
					lit_cnt--;
					void'(write_byte(b, o));
				end else begin
					if (b >= FILL_HDR) begin
						fill_cnt = b - FILL_BIAS;
						want_fill_val = 1'b1;
					end else begin
						lit_cnt = b + 8'd1;
					end
					o = outcome(0, 0, 0, 0, 0, ST_OK);
				end
				return 1'b1;
			end
			CMD_CONTINUE: begin
				if (t_cols != 0 && !t_raw && !want_fill_val && fill_cnt > 0) begin
					fill_cnt--;
					if (write_byte(fill_val, o)) o.run_pending = fill_cnt != 0;
				end else begin
					o = outcome(0, 0, 0, 0, 0, ST_OK);
				end
				return 1'b1;
			end
			CMD_END_IMAGE: begin
				o = outcome(0, 0, 0, 0, 0,
					(34'(coverage) != 34'(img_w) * 34'(img_h)) ? ST_COVERAGE : ST_OK);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic item_t mk(bit [2:0] cmd, int x1, int y1, int x2, int y2, bit rw,
			int b);
		item_t it;
		it.command = cmd;
		it.tile_x_first = x1[15:0];
		it.tile_y_first = y1[15:0];
		it.tile_x_last = x2[15:0];
		it.tile_y_last = y2[15:0];
		it.raw_mode = rw;
		it.data_byte = b[7:0];
		return it;
	endfunction

	function automatic void send(item_t it);
		stim_t s;
		s.it = it;
		s.typed = 1'b0;
		s.want = '0;
		stim_q.push_back(s);
	endfunction

	// Sender and checker share one process so that acceptance and prediction line up.
	// The predictor runs on every accepted transaction, even where the table supplies
	// the expected result, so that its state keeps pace with the block.
	always @(posedge clk) begin : xfer_blk
		result_t got;
		result_t want;
		stim_t   s;
		if (item_valid && item_ready) begin
			if (decode_item(in_flight.it, got))
				expected_q.push_back(in_flight.typed ? in_flight.want : got);
		end
		if (!item_valid || item_ready) begin
			if (stim_q.size() > 0 && !($urandom_range(0, 99) < send_idle_pct)) begin
				s = stim_q.pop_front();
				in_flight <= s;
				item <= s.it;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		if (result_valid && result_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction: %p", result);
			end else begin
				want = expected_q.pop_front();
				if (result.pixel_valid !== want.pixel_valid ||
						result.pixel_column !== want.pixel_column ||
						result.buffer_row !== want.buffer_row ||
						result.byte_lane !== want.byte_lane ||
						result.byte_value !== want.byte_value ||
						result.run_pending !== want.run_pending ||
						result.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result differs: expected %p actual %p", want, result);
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request so the block backs up.
	always @(posedge clk) begin
		if (hold_order != hold_served) begin
			hold_served <= hold_order;
			hold_left <= LONG_HOLD;
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= !($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("iff_rle_planar_tile_decoder_unit: mismatch");
			$finish;
		end
	end

	task automatic reg_write(reg_idx_t idx, bit [16:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx) << 2;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) img_w = v;
		else img_h = v;
	endtask

	// Waits until all stimulus is out and every expected result has come back, then
	// lets the pipeline settle in case the last transactions produced no result.
	task automatic drain();
		while (stim_q.size() != 0 || item_valid || expected_q.size() != 0 || hold_left != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Picks a first/last pair inside [0, lim-1], usually short.
	task automatic pick_span(int lim, output int lo, output int hi);
		lo = $urandom_range(0, lim - 1);
		hi = lo + $urandom_range(0, (lim - 1 - lo) < 2 ? (lim - 1 - lo) : 2);
		if ($urandom_range(0, 99) < 4) begin
			lo = 0;
			hi = lim - 1;
		end
	endtask

	// One tile: mostly a well-formed rectangle with a well-formed byte stream, now and
	// then a bad rectangle, a truncated stream or a stream that overruns the tile.
	task automatic gen_tile(inout int n);
		int x1, y1, x2, y2, total, rem, k, run, cap;
		bit rw;
		rw = 1'($urandom_range(0, 1));
		if (img_w == 0 || img_h == 0 || $urandom_range(0, 99) < 10) begin
			send(mk(CMD_START_TILE, $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535), rw, $urandom_range(0, 255)));
			n++;
			return;
		end
		pick_span(img_w, x1, x2);
		pick_span(img_h, y1, y2);
		send(mk(CMD_START_TILE, x1, y1, x2, y2, rw, $urandom_range(0, 255)));
		n++;
		total = (x2 - x1 + 1) * (y2 - y1 + 1);
		total = (total > 16) ? 64 : total * 4;
		rem = total;
		if ($urandom_range(0, 99) < 20) rem += $urandom_range(1, 3);
		cap = 60;
		if (rw) begin
			for (k = 0; k < rem && k < cap; k++)
				send(mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, $urandom_range(0, 255)));
			n += k;
			return;
		end
		k = 0;
		while (rem > 0 && k < cap) begin
			run = $urandom_range(1, rem < 8 ? rem : 8);
			if ($urandom_range(0, 99) < 5) run = $urandom_range(1, 128);
			if ($urandom_range(0, 1)) begin
				send(mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'h7f + run));
				send(mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, $urandom_range(0, 255)));
				k += 2;
				for (int i = 1; i < run && k < cap; i++) begin
					// A stray data byte during a pending fill is ignored by the block.
					if ($urandom_range(0, 99) < 5)
						send(mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, $urandom_range(0, 255)));
					send(mk(CMD_CONTINUE, 0, 0, 0, 0, 0, 0));
					k++;
				end
			end else begin
				send(mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, run - 1));
				k++;
				for (int i = 0; i < run && k < cap; i++) begin
					send(mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, $urandom_range(0, 255)));
					k++;
				end
			end
			rem -= run;
		end
		n += k;
	endtask

	task automatic gen_image(int budget);
		int n, roll;
		n = 0;
		send(mk(CMD_START_IMAGE, 0, 0, 0, 0, 0, 0));
		while (n < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				// Noise: any command, including the unused codes, with random fields.
				send(mk(3'($urandom_range(0, 7)), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), 1'($urandom_range(0, 1)),
					$urandom_range(0, 255)));
				n++;
			end else if (roll < 12) begin
				send(mk(CMD_END_IMAGE, 0, 0, 0, 0, 0, 0));
				n++;
			end else begin
				gen_tile(n);
			end
		end
		send(mk(CMD_END_IMAGE, 0, 0, 0, 0, 0, 0));
	endtask

	stim_t dir_tab[24];

	task automatic fill_table();
		result_t quiet, bad_rect, cover_err, ovf;
		quiet = '0;
		bad_rect = '0;
		bad_rect.status = ST_BAD_RECT;
		cover_err = '0;
		cover_err.status = ST_COVERAGE;
		ovf = '0;
		ovf.status = ST_OVERFLOW;
		foreach (dir_tab[i]) dir_tab[i].typed = 1'b0;
		// The image is 4 by 3 pixels for the whole table.
		dir_tab[0].it = mk(CMD_END_IMAGE, 0, 0, 0, 0, 0, 0);
		dir_tab[0].typed = 1; dir_tab[0].want = cover_err;
		dir_tab[1].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'hff);
		dir_tab[1].typed = 1; dir_tab[1].want = quiet;
		dir_tab[2].it = mk(CMD_CONTINUE, 0, 0, 0, 0, 0, 0);
		dir_tab[2].typed = 1; dir_tab[2].want = quiet;
		dir_tab[3].it = mk(CMD_START_TILE, 3, 0, 1, 2, 0, 0);
		dir_tab[3].typed = 1; dir_tab[3].want = bad_rect;
		dir_tab[4].it = mk(CMD_START_TILE, 0, 0, 4, 2, 0, 0);
		dir_tab[4].typed = 1; dir_tab[4].want = bad_rect;
		dir_tab[5].it = mk(CMD_START_TILE, 0, 0, 3, 2, 1, 0);
		dir_tab[5].typed = 1; dir_tab[5].want = quiet;
		dir_tab[6].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'hff);
		dir_tab[7].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'h00);
		// Single-pixel run-length tile: four planes of one byte each.
		dir_tab[8].it = mk(CMD_START_TILE, 0, 0, 0, 0, 0, 0);
		dir_tab[8].typed = 1; dir_tab[8].want = quiet;
		dir_tab[9].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'h81);
		dir_tab[9].typed = 1; dir_tab[9].want = quiet;
		dir_tab[10].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'haa);
		dir_tab[11].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'h55);
		dir_tab[12].it = mk(CMD_CONTINUE, 0, 0, 0, 0, 0, 0);
		dir_tab[13].it = mk(CMD_CONTINUE, 0, 0, 0, 0, 0, 0);
		dir_tab[14].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'h7f);
		dir_tab[15].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'h12);
		dir_tab[16].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'h34);
		dir_tab[17].it = mk(CMD_DATA_BYTE, 0, 0, 0, 0, 0, 8'h56);
		dir_tab[17].typed = 1; dir_tab[17].want = ovf;
		dir_tab[18].it = mk(3'd5, 0, 0, 0, 0, 0, 0);
		dir_tab[19].it = mk(CMD_START_IMAGE, 0, 0, 0, 0, 0, 0);
		dir_tab[20].it = mk(CMD_END_IMAGE, 0, 0, 0, 0, 0, 0);
		dir_tab[20].typed = 1; dir_tab[20].want = cover_err;
		dir_tab[21].it = mk(CMD_START_TILE, 0, 0, 3, 2, 0, 0);
		dir_tab[22].it = mk(CMD_END_IMAGE, 0, 0, 0, 0, 0, 0);
		dir_tab[22].typed = 1; dir_tab[22].want = quiet;
		dir_tab[23].it = mk(CMD_START_TILE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 8'hff);
		dir_tab[23].typed = 1; dir_tab[23].want = bad_rect;
	endtask

	// Runs one random phase at a given image size and idling mix.
	task automatic run_phase(bit [16:0] w, bit [16:0] h, int snd, int rcv, int budget,
			bit long_hold);
		reg_write(REG_IMAGE_WIDTH, w);
		reg_write(REG_IMAGE_HEIGHT, h);
		send_idle_pct = snd;
		recv_stall_pct = rcv;
		gen_image(budget);
		if (long_hold) hold_order++;
		drain();
	endtask

	initial begin
		drop_tile();
		img_w = '0;
		img_h = '0;
		coverage = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(REG_IMAGE_WIDTH, 17'd4);
		reg_write(REG_IMAGE_HEIGHT, 17'd3);
		fill_table();
		foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
		drain();

		// The long receiver hold-off lands on an unthrottled sender so the queue fills.
		run_phase(17'd5, 17'd4, 0, 0, 80, 1'b1);
		run_phase(17'd0, 17'd0, 85, 0, 30, 1'b0);
		run_phase(17'h10000, 17'h10000, 0, 85, 70, 1'b0);
		run_phase(17'($urandom_range(1, 6)), 17'($urandom_range(1, 6)), 10, 10, 80, 1'b0);
		// The sender stops here until every expected result is back, then resumes.
		run_phase(17'($urandom_range(1, 6)), 17'($urandom_range(1, 6)), 10, 10, 60, 1'b0);
		run_phase(17'd1, 17'd1, 85, 85, 40, 1'b0);
		run_phase(17'h10000, 17'd3, 0, 0, 60, 1'b0);
		run_phase(17'($urandom_range(1, 8)), 17'($urandom_range(1, 8)), 0, 85, 80, 1'b1);

		if (mismatches == 0) begin
			$display("iff_rle_planar_tile_decoder_unit: match");
		end else begin
			$display("iff_rle_planar_tile_decoder_unit: mismatch");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/irtd_pkg.sv
rtl/core/irtd_front.sv
rtl/core/irtd_fifo.sv
rtl/core/irtd_back.sv
rtl/core/iff_rle_planar_tile_decoder_unit.sv
dv/tb_iff_rle_planar_tile_decoder_unit.sv
